// File: rtl/core/esc_pkg.sv
// esc_pkg: shared widths, event/command/direction codes and the control store
// for the elevator scan controller. No dependencies.
`default_nettype none

package esc_pkg;

  // sizes
  localparam int FLOORS  = 16;
  localparam int FLOOR_W = 4;
  localparam int OP_W    = 3;
  localparam int CMD_W   = 3;
  localparam int DIR_W   = 2;
  localparam int CAR_W   = 8;
  localparam int UPC_W   = 4;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 24;

  localparam logic [CAR_W-1:0] CAR_ID_RESET = 8'd97;

  // event codes
  localparam logic [OP_W-1:0] OP_DOOR_OPENED = 3'd0;
  localparam logic [OP_W-1:0] OP_DOOR_CLOSED = 3'd1;
  localparam logic [OP_W-1:0] OP_HALL_BUTTON = 3'd2;
  localparam logic [OP_W-1:0] OP_CAR_BUTTON  = 3'd3;
  localparam logic [OP_W-1:0] OP_FLOOR_REACH = 3'd4;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LAMP_ON  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LAMP_OFF = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLOSE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UP       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DOWN     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_STOP     = 3'd5;
  localparam logic [CMD_W-1:0] CMD_OPEN     = 3'd6;

  // continue conditions: after the step's command, go on or finish
  localparam logic [1:0] CONT_END       = 2'd0;
  localparam logic [1:0] CONT_MOVING    = 2'd1;
  localparam logic [1:0] CONT_HALL_SAME = 2'd2;
  localparam logic [1:0] CONT_ALWAYS    = 2'd3;

  // program entry points
  localparam logic [UPC_W-1:0] UA_DOOR_OPENED = 4'd0;
  localparam logic [UPC_W-1:0] UA_DOOR_CLOSED = 4'd2;
  localparam logic [UPC_W-1:0] UA_HALL_BUTTON = 4'd3;
  localparam logic [UPC_W-1:0] UA_FLOOR_REACH = 4'd5;

  // one control word: command source, floor source, continue condition
  typedef struct packed {
    logic             move_sel;  // command follows travel direction
    logic [CMD_W-1:0] cmd;
    logic             tgt_sel;   // floor field from target_floor
    logic [1:0]       cont;
  } uword_t;

  // control store
  function automatic uword_t urom(input logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      // door opened
      4'd0: w = '{1'b0, CMD_LAMP_OFF, 1'b0, CONT_MOVING};
      4'd1: w = '{1'b0, CMD_CLOSE,    1'b0, CONT_END};
      // door closed
      4'd2: w = '{1'b1, CMD_STOP,     1'b0, CONT_END};
      // hall button
      4'd3: w = '{1'b0, CMD_LAMP_ON,  1'b1, CONT_HALL_SAME};
      4'd4: w = '{1'b0, CMD_LAMP_OFF, 1'b1, CONT_END};
      // floor reached with a request here
      4'd5: w = '{1'b0, CMD_STOP,     1'b0, CONT_MOVING};
      4'd6: w = '{1'b1, CMD_STOP,     1'b0, CONT_ALWAYS};
      4'd7: w = '{1'b0, CMD_STOP,     1'b0, CONT_ALWAYS};
      4'd8: w = '{1'b0, CMD_OPEN,     1'b0, CONT_END};
      default: w = '{1'b0, CMD_STOP,  1'b0, CONT_END};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/elevator_scan_controller_top.sv
// elevator_scan_controller_top: single-car collective controller driven by a
// microprogram in the control store. Depends on esc_pkg.
`default_nettype none

// An event word is taken when in_tready is high; the block then decodes it in
// ST_DECODE (updating direction and the request bitmap) and issues each
// command that the event produces in ST_RUN, stepping through the control
// store and holding while the output is stalled. An event gives no command or
// up to four commands. The output register frees the input side once the last
// command is loaded, so the next event may enter while that command still
// waits. car_id resets to 97 and is written through the cfg port; the user
// must write it only while the block is idle; the block does not enforce it.
module elevator_scan_controller_top (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata: opcode[2:0], current_floor[6:3], target_floor[10:7], zero fill
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [esc_pkg::IN_W-1:0]   in_tdata,
  // out_tdata: command[2:0], command_floor[6:3], target_car[14:7],
  // direction_after[16:15], zero fill
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [esc_pkg::OUT_W-1:0]  out_tdata,
  output logic                       out_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [esc_pkg::CAR_W-1:0]  cfg_data
);
  import esc_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DECODE = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [UPC_W-1:0]   upc_r, upc_nxt;
  logic [OP_W-1:0]    op_r;
  logic [FLOOR_W-1:0] cur_r, tgt_r;
  logic [DIR_W-1:0]   dir_r, dir_nxt;
  logic [FLOORS-1:0]  pend_r, pend_nxt;
  logic               hall_same_r, hall_same_nxt;
  logic [CAR_W-1:0]   car_id_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;
  logic               out_last_r;

  logic               in_acc;
  logic [DIR_W-1:0]   dir_old;
  logic [FLOORS-1:0]  cur_bit, tgt_bit, pend_open;
  logic               up_any, dn_any;
  logic               entry_go;
  logic [UPC_W-1:0]   entry_pc;
  uword_t             uw;
  logic [CMD_W-1:0]   move_cmd, step_cmd;
  logic [FLOOR_W-1:0] step_floor;
  logic               step_cont;
  logic               emit;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // one-hot floor bits; floors beyond the bitmap give no bit
  always_comb begin
    for (int i = 0; i < FLOORS; i++) begin
      cur_bit[i] = (int'(cur_r) == i);
      tgt_bit[i] = (int'(tgt_r) == i);
    end
  end

  // requests above and below the car after clearing the current floor
  always_comb begin
    pend_open = pend_r & ~cur_bit;
    up_any    = 1'b0;
    dn_any    = 1'b0;
    for (int i = 0; i < FLOORS; i++) begin
      up_any = up_any | (pend_open[i] & (i > int'(cur_r)));
      dn_any = dn_any | (pend_open[i] & (i < int'(cur_r)));
    end
  end

  assign dir_old = (dir_r == DIR_UP || dir_r == DIR_DOWN) ? dir_r : DIR_STOP;

  // event decode: new direction and bitmap, program entry
  always_comb begin
    dir_nxt       = dir_old;
    pend_nxt      = pend_r;
    hall_same_nxt = 1'b0;
    entry_go      = 1'b0;
    entry_pc      = UA_DOOR_OPENED;
    case (op_r)
      OP_DOOR_OPENED: begin
        pend_nxt = pend_open;
        entry_go = 1'b1;
        entry_pc = UA_DOOR_OPENED;
        if (dir_old == DIR_UP) begin
          dir_nxt = up_any ? DIR_UP : (dn_any ? DIR_DOWN : DIR_STOP);
        end else if (dir_old == DIR_DOWN) begin
          dir_nxt = dn_any ? DIR_DOWN : (up_any ? DIR_UP : DIR_STOP);
        end
      end
      OP_DOOR_CLOSED: begin
        entry_go = 1'b1;
        entry_pc = UA_DOOR_CLOSED;
      end
      OP_HALL_BUTTON: begin
        entry_go      = 1'b1;
        entry_pc      = UA_HALL_BUTTON;
        hall_same_nxt = (dir_old == DIR_STOP) && (tgt_r == cur_r);
        if (!hall_same_nxt) begin
          pend_nxt = pend_r | tgt_bit;
          if (dir_old == DIR_STOP) begin
            dir_nxt = (tgt_r < cur_r) ? DIR_DOWN : DIR_UP;
          end
        end
      end
      OP_CAR_BUTTON: begin
        pend_nxt = pend_r | tgt_bit;
        if (tgt_r > cur_r && dir_old != DIR_DOWN) begin
          dir_nxt = DIR_UP;
        end else if (tgt_r < cur_r && dir_old != DIR_UP) begin
          dir_nxt = DIR_DOWN;
        end
      end
      OP_FLOOR_REACH: begin
        entry_go = |(pend_r & cur_bit);
        entry_pc = UA_FLOOR_REACH;
      end
      default: begin
        entry_go = 1'b0;
      end
    endcase
  end

  // microprogram step: command, floor and whether the program goes on
  always_comb begin
    uw         = urom(upc_r);
    move_cmd   = (dir_r == DIR_UP) ? CMD_UP : ((dir_r == DIR_DOWN) ? CMD_DOWN : CMD_STOP);
    step_cmd   = uw.move_sel ? move_cmd : uw.cmd;
    step_floor = uw.tgt_sel ? tgt_r : cur_r;
    case (uw.cont)
      CONT_END:       step_cont = 1'b0;
      CONT_MOVING:    step_cont = (dir_r != DIR_STOP);
      CONT_HALL_SAME: step_cont = hall_same_r;
      CONT_ALWAYS:    step_cont = 1'b1;
      default:        step_cont = 1'b0;
    endcase
  end

  assign emit = (state_r == ST_RUN) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    upc_nxt   = upc_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        upc_nxt   = entry_pc;
        state_nxt = entry_go ? ST_RUN : ST_IDLE;
      end
      ST_RUN: begin
        if (emit) begin
          upc_nxt   = upc_r + UPC_W'(1);
          state_nxt = step_cont ? ST_RUN : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      upc_r       <= '0;
      dir_r       <= DIR_STOP;
      pend_r      <= '0;
      car_id_r    <= CAR_ID_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      upc_r   <= upc_nxt;
      if (state_r == ST_DECODE) begin
        dir_r  <= dir_nxt;
        pend_r <= pend_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        car_id_r <= cfg_data;
      end
      // a new word reloads the slot, otherwise an accepted word empties it
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tdata[2:0];
      cur_r <= in_tdata[6:3];
      tgt_r <= in_tdata[10:7];
    end
    if (state_r == ST_DECODE) begin
      hall_same_r <= hall_same_nxt;
    end
    if (emit) begin
      out_data_r <= {7'b0, dir_r, car_id_r, step_floor, step_cmd};
      out_last_r <= !step_cont;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/esc_checker.sv
// esc_checker: port-level checks for elevator_scan_controller_top, attached
// by the bind below. Depends on esc_pkg.
`default_nettype none

module esc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [esc_pkg::OUT_W-1:0] out_tdata,
  input logic                      out_tlast
);
  import esc_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  // an accepted event keeps the input closed during decode
  a_decode_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken during decode");

  // commands are only the seven defined codes
  a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] != 3'd7)
    else $error("undefined command code");

  // direction code three is never reported
  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[16:15] != 2'd3)
    else $error("undefined direction code");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind elevator_scan_controller_top esc_checker u_esc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
